>>> hw/rtl/matrix3_inverse_top_assert.svh
// Assertion helpers for the 3x3 inverse block.
`ifndef MATRIX3_INVERSE_TOP_ASSERT_SVH
`define MATRIX3_INVERSE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define M3I_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define M3I_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/m3i_pkg.sv
package m3i_pkg;

  localparam int ELEM_W = 24;
  localparam int COF_W  = 49;              // cofactor, signed
  localparam int DET_W  = 75;              // determinant, signed Q24.48 with headroom
  localparam int NUM_W  = 80;              // |cofactor| << 32
  localparam int QB     = 25;              // quotient bits resolved by the divider
  localparam int CMP_W  = DET_W + QB;      // divider compare width
  localparam int THR_W  = 32;
  localparam int QD     = 4;               // front/back queue depth
  localparam int QA_W   = $clog2(QD);
  localparam int QC_W   = $clog2(QD + 1);

  localparam logic [QB-1:0] Q_POS_MAX = QB'(8388607);
  localparam logic [QB-1:0] Q_NEG_MAX = QB'(8388608);

  localparam logic REG_DET_THRESHOLD = 1'b0;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [COF_W-1:0]  cof_t;
  typedef logic [DET_W-1:0]         dmag_t;
  typedef logic [NUM_W-1:0]         num_t;

  typedef struct packed {
    cof_t [8:0] n;
    dmag_t      dmag;
    logic       dneg;
    logic       singular;
  } fitem_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> hw/rtl/m3i_queue.sv
module m3i_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  m3i_pkg::fitem_t   item_i,
  input  logic              pop_i,
  output m3i_pkg::fitem_t   head_o,
  output m3i_pkg::q_stat_t  stat_o
);
  import m3i_pkg::*;

  fitem_t          mem_q [QD];
  logic [QA_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QC_W-1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + QA_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + QA_W'(1);
      if (push_i && !pop_i)      cnt_q <= cnt_q + QC_W'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - QC_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= item_i;
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == QC_W'(QD));
  assign stat_o.empty = (cnt_q == '0);

endmodule

>>> hw/rtl/m3i_div_lane.sv
module m3i_div_lane (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  m3i_pkg::cof_t           n_i,
  input  logic                    dneg_i,
  input  m3i_pkg::dmag_t          den_i [m3i_pkg::QB+1],
  output logic [m3i_pkg::QB-1:0]  q_o,
  output logic                    big_o,
  output logic                    neg_o
);
  import m3i_pkg::*;

  num_t            rem_q [QB+2];
  logic            neg_q [QB+2];
  logic            big_q [1:QB+1];
  logic [QB-1:0]   q_q   [1:QB+1];
  cof_t            mag;
  logic [CMP_W-1:0] big_lhs, big_rhs;

  assign mag     = n_i[COF_W-1] ? -n_i : n_i;
  assign big_lhs = CMP_W'(rem_q[0]);
  assign big_rhs = CMP_W'(den_i[0]) << QB;

  // entry and quotient overflow check
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= {mag[NUM_W-33:0], 32'b0};
      neg_q[0] <= n_i[COF_W-1] ^ dneg_i;
      rem_q[1] <= rem_q[0];
      neg_q[1] <= neg_q[0];
      big_q[1] <= (big_lhs >= big_rhs);
      q_q[1]   <= '0;
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar s = 2; s <= QB + 1; s++) begin : g_bit
    localparam int K = QB + 1 - s;
    logic [CMP_W-1:0] lhs, rhs, diff;
    logic             ge;
    assign lhs  = CMP_W'(rem_q[s-1]);
    assign rhs  = CMP_W'(den_i[s-1]) << K;
    assign ge   = (lhs >= rhs);
    assign diff = lhs - rhs;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s] <= ge ? diff[NUM_W-1:0] : rem_q[s-1];
        q_q[s]   <= q_q[s-1] | (ge ? (QB'(1) << K) : QB'(0));
        big_q[s] <= big_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  assign q_o   = q_q[QB+1];
  assign big_o = big_q[QB+1];
  assign neg_o = neg_q[QB+1];

endmodule

>>> hw/rtl/m3i_front.sv
module m3i_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  m3i_pkg::elem_t             a_i [9],
  input  logic [m3i_pkg::THR_W-1:0]  thr_i,
  input  m3i_pkg::q_stat_t           qstat_i,
  output logic                       push_o,
  output m3i_pkg::fitem_t            item_o
);
  import m3i_pkg::*;

  // operand pairs of each cofactor, flat index r*3+c: n = A*B - C*D
  localparam int unsigned IA [9] = '{4, 7, 1, 6, 0, 3, 3, 6, 0};
  localparam int unsigned IB [9] = '{8, 2, 5, 5, 8, 2, 7, 1, 4};
  localparam int unsigned IC [9] = '{7, 1, 4, 3, 6, 0, 6, 0, 3};
  localparam int unsigned ID [9] = '{5, 8, 2, 8, 2, 5, 4, 7, 1};

  logic [7:0]              v_q;
  logic                    en;
  elem_t                   a0_q   [9];
  logic signed [47:0]      pa1_q  [9];
  logic signed [47:0]      pb1_q  [9];
  elem_t                   col1_q [3];
  cof_t                    n2_q   [9];
  elem_t                   col2_q [3];
  logic signed [49:0]      plo3_q [3];
  logic signed [47:0]      phi3_q [3];
  cof_t                    n3_q   [9];
  logic signed [72:0]      t4_q   [3];
  cof_t                    n4_q   [9];
  logic signed [DET_W-1:0] det5_q;
  cof_t                    n5_q   [9];
  dmag_t                   dmag6_q;
  logic                    dneg6_q;
  cof_t                    n6_q   [9];
  dmag_t                   dmag7_q;
  logic                    dneg7_q;
  logic                    sing7_q;
  cof_t                    n7_q   [9];

  assign en         = !(v_q[7] && qstat_i.full);
  assign in_stall_o = !en;
  assign push_o     = v_q[7] && !qstat_i.full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a0_q <= a_i;
      for (int k = 0; k < 9; k++) begin
        pa1_q[k] <= a0_q[IA[k]] * a0_q[IB[k]];
        pb1_q[k] <= a0_q[IC[k]] * a0_q[ID[k]];
        n2_q[k]  <= cof_t'(pa1_q[k]) - cof_t'(pb1_q[k]);
      end
      for (int j = 0; j < 3; j++) begin
        col1_q[j] <= a0_q[3*j];
        col2_q[j] <= col1_q[j];
        // det term a[j][0] * n[0][j], split into two narrower products
        plo3_q[j] <= col2_q[j] * $signed({1'b0, n2_q[j][24:0]});
        phi3_q[j] <= col2_q[j] * $signed(n2_q[j][48:25]);
        t4_q[j]   <= (73'(phi3_q[j]) <<< 25) + 73'(plo3_q[j]);
      end
      n3_q    <= n2_q;
      n4_q    <= n3_q;
      det5_q  <= DET_W'(t4_q[0]) + DET_W'(t4_q[1]) + DET_W'(t4_q[2]);
      n5_q    <= n4_q;
      dneg6_q <= det5_q[DET_W-1];
      dmag6_q <= det5_q[DET_W-1] ? dmag_t'(-det5_q) : dmag_t'(det5_q);
      n6_q    <= n5_q;
      dneg7_q <= dneg6_q;
      dmag7_q <= dmag6_q;
      sing7_q <= (dmag6_q[DET_W-1:32] <= (DET_W-32)'(thr_i));
      n7_q    <= n6_q;
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) item_o.n[k] = n7_q[k];
    item_o.dmag     = dmag7_q;
    item_o.dneg     = dneg7_q;
    item_o.singular = sing7_q;
  end

endmodule

>>> hw/rtl/m3i_back.sv
module m3i_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  m3i_pkg::fitem_t   head_i,
  input  m3i_pkg::q_stat_t  qstat_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output m3i_pkg::elem_t    inv_o [9],
  output logic              singular_o,
  output logic              saturated_o
);
  import m3i_pkg::*;

  localparam int LAST = QB + 2;

  logic [LAST:0]   v_q;
  logic            en;
  dmag_t           den_q [QB+1];
  logic            sg_q  [QB+2];
  logic [QB-1:0]   q     [9];
  logic            big   [9];
  logic            neg   [9];
  elem_t           elem_d [9];
  logic            sat_d;
  elem_t           inv_q [9];
  logic            sing_q, sat_q;

  assign en    = !(v_q[LAST] && out_stall_i);
  assign pop_o = en && !qstat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAST-1:0], !qstat_i.empty};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      den_q[0] <= head_i.dmag;
      sg_q[0]  <= head_i.singular;
      for (int s = 1; s <= QB; s++) den_q[s] <= den_q[s-1];
      for (int s = 1; s <= QB + 1; s++) sg_q[s] <= sg_q[s-1];
    end
  end

  for (genvar l = 0; l < 9; l++) begin : g_lane
    m3i_div_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .n_i    (head_i.n[l]),
      .dneg_i (head_i.dneg),
      .den_i  (den_q),
      .q_o    (q[l]),
      .big_o  (big[l]),
      .neg_o  (neg[l])
    );
  end

  // clamp to Q8.16, apply sign, zero out singular matrices
  always_comb begin
    logic [QB-1:0] lim, mag;
    logic          clip;
    sat_d = 1'b0;
    for (int l = 0; l < 9; l++) begin
      lim  = neg[l] ? Q_NEG_MAX : Q_POS_MAX;
      clip = big[l] || (q[l] > lim);
      mag  = clip ? lim : q[l];
      elem_d[l] = neg[l] ? elem_t'(~mag + QB'(1)) : elem_t'(mag);
      if (clip) sat_d = 1'b1;
      if (sg_q[QB+1]) elem_d[l] = '0;
    end
    if (sg_q[QB+1]) sat_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv_q  <= elem_d;
      sing_q <= sg_q[QB+1];
      sat_q  <= sat_d;
    end
  end

  assign out_valid_o = v_q[LAST];
  assign inv_o       = inv_q;
  assign singular_o  = sing_q;
  assign saturated_o = sat_q;

endmodule

>>> hw/rtl/matrix3_inverse_top.sv
// 3x3 matrix inverse, signed Q8.16 in and out. One matrix per beat on the
// input channel, one result beat per matrix, in order. The block takes a new
// matrix every clock while nothing stalls. The path runs through seven more
// front stages after the input register (eight cofactor/determinant stages in
// all), a write into the four-deep queue, and 28 back stages fed from the
// queue head. The back stages are operand entry, an overflow check, one
// restoring divider stage per quotient bit (25 bits, nine lanes side by side)
// and the output register. The divider makes up most of the pipeline. Each
// element is cofactor * 2^32 / det, truncated toward zero and clamped to
// Q8.16; saturated_o flags a clamp. If |det| in Q16.16 is at or below
// det_threshold (APB offset 0x0, reset 0), singular_o is set and all elements
// are zero. Write the threshold only while idle.
module matrix3_inverse_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB config port
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  m3i_pkg::elem_t       a_r0c0_i,
  input  m3i_pkg::elem_t       a_r0c1_i,
  input  m3i_pkg::elem_t       a_r0c2_i,
  input  m3i_pkg::elem_t       a_r1c0_i,
  input  m3i_pkg::elem_t       a_r1c1_i,
  input  m3i_pkg::elem_t       a_r1c2_i,
  input  m3i_pkg::elem_t       a_r2c0_i,
  input  m3i_pkg::elem_t       a_r2c1_i,
  input  m3i_pkg::elem_t       a_r2c2_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output m3i_pkg::elem_t       inv_r0c0_o,
  output m3i_pkg::elem_t       inv_r0c1_o,
  output m3i_pkg::elem_t       inv_r0c2_o,
  output m3i_pkg::elem_t       inv_r1c0_o,
  output m3i_pkg::elem_t       inv_r1c1_o,
  output m3i_pkg::elem_t       inv_r1c2_o,
  output m3i_pkg::elem_t       inv_r2c0_o,
  output m3i_pkg::elem_t       inv_r2c1_o,
  output m3i_pkg::elem_t       inv_r2c2_o,
  output logic                 singular_o,
  output logic                 saturated_o
);
  import m3i_pkg::*;

  `include "matrix3_inverse_top_assert.svh"

  logic [THR_W-1:0] thr_q;
  logic             cfg_wr;
  elem_t            a     [9];
  elem_t            inv   [9];
  logic             inv_zero;
  logic             q_push, q_pop;
  fitem_t           q_in, q_head;
  q_stat_t          q_stat;

  // --- config register ---
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_DET_THRESHOLD);
  assign prdata = (paddr[2] == REG_DET_THRESHOLD) ? thr_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_wr) begin
      thr_q <= pwdata;
    end
  end

  assign a = '{a_r0c0_i, a_r0c1_i, a_r0c2_i,
               a_r1c0_i, a_r1c1_i, a_r1c2_i,
               a_r2c0_i, a_r2c1_i, a_r2c2_i};

  // Front: cofactors, determinant, singular test.
  m3i_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .a_i        (a),
    .thr_i      (thr_q),
    .qstat_i    (q_stat),
    .push_o     (q_push),
    .item_o     (q_in)
  );

  // Queue decouples front stalls from back stalls.
  m3i_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_in),
    .pop_i  (q_pop),
    .head_o (q_head),
    .stat_o (q_stat)
  );

  // Back: nine pipelined dividers, clamp, output register.
  m3i_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .qstat_i     (q_stat),
    .pop_o       (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .inv_o       (inv),
    .singular_o  (singular_o),
    .saturated_o (saturated_o)
  );

  assign inv_r0c0_o = inv[0];
  assign inv_r0c1_o = inv[1];
  assign inv_r0c2_o = inv[2];
  assign inv_r1c0_o = inv[3];
  assign inv_r1c1_o = inv[4];
  assign inv_r1c2_o = inv[5];
  assign inv_r2c0_o = inv[6];
  assign inv_r2c1_o = inv[7];
  assign inv_r2c2_o = inv[8];

  // all nine elements zero
  assign inv_zero = (inv[0] == '0) && (inv[1] == '0) && (inv[2] == '0) &&
                    (inv[3] == '0) && (inv[4] == '0) && (inv[5] == '0) &&
                    (inv[6] == '0) && (inv[7] == '0) && (inv[8] == '0);

  // --- checks ---
  `M3I_ASSERT_IMP(a_sing_zero, out_valid_o && singular_o, !saturated_o && inv_zero, "singular result not zero")
  `M3I_ASSERT_IMP(a_q_no_ovf, q_push, !q_stat.full, "queue push while full")
  `M3I_ASSERT_IMP(a_q_no_udf, q_pop, !q_stat.empty, "queue pop while empty")
  `M3I_ASSERT_NXT(a_cfg_wr, cfg_wr, thr_q == $past(pwdata), "threshold write lost")

endmodule
